// File: rtl/mvp_pkg.sv
// Shared constants, codes and tables of the mixer volume programmer.
`default_nettype none

package mvp_pkg;

   localparam int unsigned NUM_DEVICES_DEF = 6;
   localparam int unsigned DEV_W           = 3;
   localparam int unsigned VOL_IN_W        = 8;
   localparam int unsigned VOL_W           = 7;
   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned CODE_W          = 7;

   localparam logic [VOL_IN_W-1:0] VOL_MAX = 8'd100;

   // Request codes
   localparam logic FUNC_SET = 1'b0;
   localparam logic FUNC_GET = 1'b1;

   // Result kinds and bus ports
   localparam logic KIND_BUS   = 1'b0;
   localparam logic KIND_REPLY = 1'b1;
   localparam logic PORT_SEL   = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   // Routing words
   localparam logic [1:0] ROUTE_LEFT  = 2'd1;
   localparam logic [1:0] ROUTE_RIGHT = 2'd2;

   // Per-device flipped left routing word; right is the other one
   localparam logic [1:0] FLIP_LEFT [8] = '{2'd1, 2'd1, 2'd1, 2'd2, 2'd1, 2'd2, 2'd1, 2'd1};

   typedef logic [3:0] step_type;
   localparam step_type STEP_FIRST = 4'd0;
   localparam step_type STEP_REPLY = 4'd8;

endpackage

`default_nettype wire

// File: rtl/mvp_channels.sv
// Valid/ready channel interfaces: request, response and flip register write.
`default_nettype none

interface mvp_req_if import mvp_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                func;
   logic [DEV_W-1:0]    device;
   logic [VOL_IN_W-1:0] left_volume;
   logic [VOL_IN_W-1:0] right_volume;

   modport source (output valid, func, device, left_volume, right_volume, input ready);
   modport sink   (input valid, func, device, left_volume, right_volume, output ready);
endinterface

interface mvp_rsp_if import mvp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic              port;
   logic [BYTE_W-1:0] bus_byte;
   logic [VOL_W-1:0]  reply_left;
   logic [VOL_W-1:0]  reply_right;
   logic              last;

   modport source (output valid, kind, port, bus_byte, reply_left, reply_right, last,
                   input ready);
   modport sink   (input valid, kind, port, bus_byte, reply_left, reply_right, last,
                   output ready);
endinterface

interface mvp_csr_if import mvp_pkg::*; ();
   logic valid;
   logic ready;
   logic flip_enable;

   modport source (output valid, flip_enable, input ready);
   modport sink   (input valid, flip_enable, output ready);
endinterface

`default_nettype wire

// File: rtl/mixer_volume_programmer.sv
// Mixer volume programmer: request decode, volume store and bus write sequencer.
// A transfer loads the item register; results then go from it to the response register.
// A set gives 8 bus writes and a reply, one per cycle through the step counter while
//   the response register is free; a get or an out-of-range device gives only the reply.
// The next request is taken in the cycle the current reply loads the response register.
// Reset (synchronous, active high): store cleared to zero, flip_enable set, channels idle.
`default_nettype none

module mixer_volume_programmer import mvp_pkg::*; #(
   parameter int unsigned NUM_DEVICES = NUM_DEVICES_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   mvp_req_if.sink   req_ch,
   mvp_rsp_if.source rsp_ch,
   mvp_csr_if.sink   csr_ch
);

   localparam int unsigned IDX_W      = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
   localparam int unsigned RECIP_100  = 1311;   // ceil(2^17/100), exact floor for x <= 3150
   localparam int unsigned RECIP_SH   = 17;

   // Request held while its bus writes go out
   typedef struct packed {
      logic [DEV_W-1:0]  dev;
      logic [1:0]        route_l;
      logic [1:0]        route_r;
      logic [CODE_W-1:0] code_l;
      logic [CODE_W-1:0] code_r;
      logic [VOL_W-1:0]  reply_l;
      logic [VOL_W-1:0]  reply_r;
   } item_type;

   typedef logic [2*VOL_W-1:0] pair_type;

   // Attenuation code: s = (31*v + 50)/100, normalized to mantissa/exponent
   function automatic logic [CODE_W-1:0] atten_code(input logic [VOL_W-1:0] v);
      logic [11:0]       x;
      logic [22:0]       p;
      logic [4:0]        s;
      logic [4:0]        n;
      logic [2:0]        e;
      logic [CODE_W-1:0] code;
      x = 12'(v) * 12'd31 + 12'd50;
      p = 23'(x) * 23'(RECIP_100);
      s = p[RECIP_SH+4:RECIP_SH];
      if (s[4]) begin
         e = 3'd7; n = s;
      end else if (s[3]) begin
         e = 3'd6; n = {s[3:0], 1'b0};
      end else if (s[2]) begin
         e = 3'd5; n = {s[2:0], 2'b0};
      end else if (s[1]) begin
         e = 3'd4; n = {s[1:0], 3'b0};
      end else begin
         e = 3'd3; n = {s[0], 4'b0};
      end
      if (s == 5'd0) begin
         code = '0;
      end else begin
         code = {e, n[3:0]};
      end
      return code;
   endfunction

   function automatic logic [VOL_W-1:0] clamp_vol(input logic [VOL_IN_W-1:0] v);
      logic [VOL_IN_W-1:0] c;
      c = (v > VOL_MAX) ? VOL_MAX : v;
      return c[VOL_W-1:0];
   endfunction

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   logic     flip_ff,  flip_in;
   logic     busy_ff,  busy_in;
   step_type step_ff,  step_in;
   item_type item_ff,  item_in;
   pair_type store_ff [NUM_DEVICES];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff,  rsp_kind_in;
   logic              rsp_port_ff,  rsp_port_in;
   logic [BYTE_W-1:0] rsp_byte_ff,  rsp_byte_in;
   logic [VOL_W-1:0]  rsp_left_ff,  rsp_left_in;
   logic [VOL_W-1:0]  rsp_right_ff, rsp_right_in;
   logic              rsp_last_ff,  rsp_last_in;

   // ---------------------------------------------------------------
   // Request decode
   // ---------------------------------------------------------------
   logic             req_xfer;
   logic             out_load;
   logic             dev_ok;
   logic             is_set;
   logic [IDX_W-1:0] dev_idx;
   logic [VOL_W-1:0] lv_c;
   logic [VOL_W-1:0] rv_c;
   pair_type         stored_rd;
   logic [1:0]       flip_l;

   // While busy, the response register loads when empty or when its transfer completes
   assign out_load = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   // Next request enters when idle, or as the reply of the current one is loaded
   assign req_ch.ready = !busy_ff || (out_load && (step_ff == STEP_REPLY));
   assign req_xfer     = req_ch.valid && req_ch.ready;

   assign dev_ok   = 32'(req_ch.device) < NUM_DEVICES;
   assign is_set   = dev_ok && (req_ch.func == FUNC_SET);
   assign dev_idx  = req_ch.device[IDX_W-1:0];
   assign lv_c     = clamp_vol(req_ch.left_volume);
   assign rv_c     = clamp_vol(req_ch.right_volume);
   assign stored_rd = dev_ok ? store_ff[dev_idx] : '0;
   assign flip_l   = flip_ff ? FLIP_LEFT[req_ch.device] : ROUTE_LEFT;

   assign csr_ch.ready = 1'b1;

   // ---------------------------------------------------------------
   // Sequencer next state
   // ---------------------------------------------------------------
   logic             side;
   logic [1:0]       sub;

   assign side = step_ff[2];
   assign sub  = step_ff[1:0];

   always_comb begin
      flip_in = flip_ff;
      if (csr_ch.valid) begin
         flip_in = csr_ch.flip_enable;
      end

      busy_in = busy_ff;
      step_in = step_ff;
      item_in = item_ff;
      if (out_load) begin
         if (step_ff == STEP_REPLY) begin
            busy_in = 1'b0;
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
      if (req_xfer) begin
         busy_in         = 1'b1;
         // a get or an unknown device goes straight to the reply
         step_in         = is_set ? STEP_FIRST : STEP_REPLY;
         item_in.dev     = req_ch.device;
         item_in.route_l = flip_l;
         item_in.route_r = 2'd3 - flip_l;
         item_in.code_l  = atten_code(lv_c);
         item_in.code_r  = atten_code(rv_c);
         if (is_set) begin
            item_in.reply_l = lv_c;
            item_in.reply_r = rv_c;
         end else begin
            item_in.reply_l = stored_rd[VOL_W-1:0];
            item_in.reply_r = stored_rd[2*VOL_W-1:VOL_W];
         end
      end

      // Response register
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_port_in  = rsp_port_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         if (step_ff == STEP_REPLY) begin
            rsp_kind_in  = KIND_REPLY;
            rsp_port_in  = PORT_SEL;
            rsp_byte_in  = '0;
            rsp_left_in  = item_ff.reply_l;
            rsp_right_in = item_ff.reply_r;
            rsp_last_in  = 1'b1;
         end else begin
            rsp_kind_in  = KIND_BUS;
            rsp_port_in  = sub[0] ? PORT_DATA : PORT_SEL;
            rsp_left_in  = '0;
            rsp_right_in = '0;
            rsp_last_in  = 1'b0;
            case (sub)
               2'd1:    rsp_byte_in = {6'b0, side ? item_ff.route_r : item_ff.route_l};
               2'd3:    rsp_byte_in = {1'b0, side ? item_ff.code_r : item_ff.code_l};
               // select: device<<3 | volume/route register pair | side
               default: rsp_byte_in = {2'b00, item_ff.dev, 1'b0, sub[1], side};
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flip_ff      <= 1'b1;
         busy_ff      <= 1'b0;
         step_ff      <= STEP_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         flip_ff      <= flip_in;
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff      <= item_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Volume store: written when a set to a valid device transfers; the next request sees it
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DEVICES; i++) begin
            store_ff[i] <= '0;
         end
      end else if (req_xfer && is_set) begin
         store_ff[dev_idx] <= {rv_c, lv_c};
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.kind        = rsp_kind_ff;
   assign rsp_ch.port        = rsp_port_ff;
   assign rsp_ch.bus_byte    = rsp_byte_ff;
   assign rsp_ch.reply_left  = rsp_left_ff;
   assign rsp_ch.reply_right = rsp_right_ff;
   assign rsp_ch.last        = rsp_last_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_last_is_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_last_ff == (rsp_kind_ff == KIND_REPLY)))
      else $error("last flag does not match reply kind");

   a_xfer_busy: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> busy_ff)
      else $error("sequencer idle after request transfer");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= STEP_REPLY))
      else $error("step counter out of range");

   a_bus_dev_ok: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && (step_ff != STEP_REPLY)) |-> (32'(item_ff.dev) < NUM_DEVICES))
      else $error("bus writes for a device out of range");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !(out_load && (step_ff == STEP_REPLY))) |-> !req_ch.ready)
      else $error("request taken before the reply of the current one");

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for the mixer volume programmer: set/get traffic, routing, codes.
`default_nettype none

module tb import mvp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // Budget for the watchdog: ~160 requests * 9 results, each behind the longest random
   // stall; this allows roughly nine times that.
   localparam time RUN_LIMIT_NS = 5_000_000;
   // How long the response side refuses transfers in the back-pressure phase.
   localparam int  LONG_HOLD_CYCLES = 80;
   // Quiet cycles after the last expected result before the verdict.
   localparam int  DRAIN_CYCLES = 20;

   // Left routing word per device with flipping on; right is always the other word.
   localparam logic [1:0] FLIPPED_LEFT_ROUTE [8] = '{ROUTE_LEFT, ROUTE_LEFT, ROUTE_LEFT,
      ROUTE_RIGHT, ROUTE_LEFT, ROUTE_RIGHT, ROUTE_LEFT, ROUTE_LEFT};

   typedef struct packed {
      logic                func;
      logic [DEV_W-1:0]    device;
      logic [VOL_IN_W-1:0] left_volume;
      logic [VOL_IN_W-1:0] right_volume;
   } mixer_request_type;

   typedef struct packed {
      logic              kind;
      logic              port;
      logic [BYTE_W-1:0] bus_byte;
      logic [VOL_W-1:0]  reply_left;
      logic [VOL_W-1:0]  reply_right;
      logic              last;
   } mixer_result_type;

   typedef struct packed {
      logic [VOL_W-1:0] left;
      logic [VOL_W-1:0] right;
   } volume_pair_type;

   logic clock;
   logic reset;

   mvp_req_if req_ch ();
   mvp_rsp_if rsp_ch ();
   mvp_csr_if csr_ch ();

   mixer_volume_programmer uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Requests waiting for the driver, and bus writes/replies still owed by the block.
   mixer_request_type pending_requests [$];
   mixer_result_type  expected_mixer_results [$];

   // Shadow of the block state: stored volume pairs and the flip register.
   volume_pair_type shadow_volumes [NUM_DEVICES_DEF];
   logic            shadow_flip;

   int unsigned fail_count;

   // Knobs set by the sequence between phases.
   bit sender_idle_on;
   bit receiver_idle_on;
   bit rsp_hold_request;   // kicks off the long response stall
   bit rsp_hold;           // response side refuses everything while high

   // Driver-owned view of the request channel.
   mixer_request_type in_flight_request;
   bit                sender_busy;
   int unsigned       send_gap;
   int unsigned       rsp_stall;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: the run must be well over by now.
   initial begin
      #(RUN_LIMIT_NS);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Volume (0..100) to attenuation code: scale to 0..31, then normalize to a
   // 4-bit mantissa with an exponent that counts down from 7 per left shift.
   function automatic logic [CODE_W-1:0] vol_to_atten(logic [VOL_W-1:0] vol);
      int unsigned scaled;
      int unsigned expo;
      scaled = (31 * int'(vol) + 50) / 100;
      expo   = 7;
      if (scaled == 0) return '0;
      while (scaled < 16) begin
         scaled = scaled << 1;
         expo   = expo - 1;
      end
      return CODE_W'((expo << 4) + (scaled - 16));
   endfunction

   function automatic void expect_bus_write(logic port, logic [BYTE_W-1:0] data);
      mixer_result_type r;
      r          = '0;
      r.kind     = KIND_BUS;
      r.port     = port;
      r.bus_byte = data;
      expected_mixer_results.push_back(r);
   endfunction

   function automatic void expect_reply(volume_pair_type pair);
      mixer_result_type r;
      r             = '0;
      r.kind        = KIND_REPLY;
      r.port        = PORT_SEL;
      r.reply_left  = pair.left;
      r.reply_right = pair.right;
      r.last        = 1'b1;
      expected_mixer_results.push_back(r);
   endfunction

   // Everything one accepted request should produce, in order.
   function automatic void predict_mixer_traffic(mixer_request_type rq);
      logic [VOL_IN_W-1:0] lv;
      logic [VOL_IN_W-1:0] rv;
      logic [VOL_W-1:0]    vol;
      logic [1:0]          route;
      logic [BYTE_W-1:0]   base;
      volume_pair_type     pair;
      // Out-of-range device: lone empty reply, store untouched, set or get alike.
      if (rq.device >= NUM_DEVICES_DEF) begin
         expect_reply('0);
         return;
      end
      if (rq.func == FUNC_SET) begin
         lv   = (rq.left_volume  > VOL_MAX) ? VOL_MAX : rq.left_volume;
         rv   = (rq.right_volume > VOL_MAX) ? VOL_MAX : rq.right_volume;
         base = BYTE_W'(rq.device) << 3;
         for (int side = 0; side < 2; side++) begin
            vol = VOL_W'((side == 0) ? lv : rv);
            if (shadow_flip) begin
               route = FLIPPED_LEFT_ROUTE[rq.device];
               if (side == 1) route = (route == ROUTE_LEFT) ? ROUTE_RIGHT : ROUTE_LEFT;
            end else begin
               route = (side == 0) ? ROUTE_LEFT : ROUTE_RIGHT;
            end
            // routing register select, routing word, attenuation select, code
            expect_bus_write(PORT_SEL,  base | BYTE_W'(side));
            expect_bus_write(PORT_DATA, BYTE_W'(route));
            expect_bus_write(PORT_SEL,  base | BYTE_W'(2 + side));
            expect_bus_write(PORT_DATA, BYTE_W'(vol_to_atten(vol)));
         end
         pair.left  = VOL_W'(lv);
         pair.right = VOL_W'(rv);
         shadow_volumes[rq.device] = pair;
      end
      expect_reply(shadow_volumes[rq.device]);
   endfunction

   // ---------------------------------------------------------------------------
   // Idle-length picker: mostly short gaps, now and then a long one
   // ---------------------------------------------------------------------------
   function automatic int unsigned pick_idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 8);
      return $urandom_range(15, 30);
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: pops pending_requests, predicts on each transfer
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         // Transfer at this edge: book the results it owes.
         if (req_ch.valid && req_ch.ready) begin
            predict_mixer_traffic(in_flight_request);
            sender_busy = 1'b0;
         end
         // Channel free (nothing offered, or the offer just went through).
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_ch.valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
               in_flight_request = pending_requests.pop_front();
               sender_busy = 1'b1;
               req_ch.valid        <= 1'b1;
               req_ch.func         <= in_flight_request.func;
               req_ch.device       <= in_flight_request.device;
               req_ch.left_volume  <= in_flight_request.left_volume;
               req_ch.right_volume <= in_flight_request.right_volume;
               // gap before the following request, if idling is on
               send_gap = (sender_idle_on && $urandom_range(0, 2) == 0) ?
                          pick_idle_length() : 0;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Response monitor: checks each transfer against the oldest expectation
   // ---------------------------------------------------------------------------
   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      mixer_result_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_mixer_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual kind %0d byte %0d",
                        $time, rsp_ch.kind, rsp_ch.bus_byte);
               fail_count++;
            end else begin
               want = expected_mixer_results.pop_front();
               check_field("kind",        want.kind,        rsp_ch.kind);
               check_field("port",        want.port,        rsp_ch.port);
               check_field("bus_byte",    want.bus_byte,    rsp_ch.bus_byte);
               check_field("reply_left",  want.reply_left,  rsp_ch.reply_left);
               check_field("reply_right", want.reply_right, rsp_ch.reply_right);
               check_field("last",        want.last,        rsp_ch.last);
            end
         end
         // Ready for the next cycle: long hold wins, then random stalls.
         if (rsp_hold) begin
            rsp_ch.ready <= 1'b0;
         end else if (rsp_stall > 0) begin
            rsp_stall = rsp_stall - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (receiver_idle_on && $urandom_range(0, 3) == 0) rsp_stall = pick_idle_length();
         end
      end
   end

   // Long response stall, counted here so the sender keeps pushing meanwhile;
   // the block fills up and has to drop its request ready.
   initial begin
      rsp_hold = 1'b0;
      wait (rsp_hold_request);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // ---------------------------------------------------------------------------
   // Sequence helpers
   // ---------------------------------------------------------------------------
   task automatic queue_request(logic func, logic [DEV_W-1:0] dev,
                                logic [VOL_IN_W-1:0] lv, logic [VOL_IN_W-1:0] rv);
      mixer_request_type rq;
      rq.func         = func;
      rq.device       = dev;
      rq.left_volume  = lv;
      rq.right_volume = rv;
      pending_requests.push_back(rq);
   endtask

   function automatic logic [VOL_IN_W-1:0] random_volume();
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return VOL_MAX;
         2: return VOL_IN_W'($urandom_range(101, 255));
         default: return VOL_IN_W'($urandom_range(0, 100));
      endcase
   endfunction

   // Mostly sets to valid devices; some gets and some out-of-range devices.
   task automatic queue_random_requests(int unsigned count);
      logic             func;
      logic [DEV_W-1:0] dev;
      repeat (count) begin
         func = ($urandom_range(0, 3) == 0) ? FUNC_GET : FUNC_SET;
         dev  = ($urandom_range(0, 9) == 0) ? DEV_W'($urandom_range(NUM_DEVICES_DEF, 7)) :
                                              DEV_W'($urandom_range(0, NUM_DEVICES_DEF - 1));
         queue_request(func, dev, random_volume(), random_volume());
      end
   endtask

   // Block is idle once nothing is queued, offered or owed.
   task automatic wait_all_done();
      while (pending_requests.size() != 0 || sender_busy ||
             expected_mixer_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_flip(logic value);
      @(posedge clock);
      csr_ch.valid       <= 1'b1;
      csr_ch.flip_enable <= value;
      do @(posedge clock); while (!(csr_ch.valid && csr_ch.ready));
      shadow_flip = value;
      csr_ch.valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      // every block input known from time zero
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_SET;
      req_ch.device       = '0;
      req_ch.left_volume  = '0;
      req_ch.right_volume = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.flip_enable  = 1'b1;
      fail_count          = 0;
      shadow_flip         = 1'b1;
      sender_busy         = 1'b0;
      send_gap            = 0;
      rsp_stall           = 0;
      sender_idle_on      = 1'b1;
      receiver_idle_on    = 1'b1;
      rsp_hold_request    = 1'b0;
      for (int d = 0; d < NUM_DEVICES_DEF; d++) shadow_volumes[d] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part, flip at its reset value.
      queue_request(FUNC_GET, 3'd0, 8'd0,   8'd0);     // store still at reset
      queue_request(FUNC_GET, 3'd5, 8'd255, 8'd255);
      queue_request(FUNC_SET, 3'd0, 8'd0,   8'd0);     // zero volume -> zero code
      queue_request(FUNC_SET, 3'd1, 8'd255, 8'd255);   // both clamped
      queue_request(FUNC_SET, 3'd2, 8'd100, 8'd101);   // clamp boundary
      queue_request(FUNC_SET, 3'd3, 8'd1,   8'd2);     // scaled 0 vs first nonzero
      queue_request(FUNC_SET, 3'd4, 8'd3,   8'd4);
      queue_request(FUNC_SET, 3'd5, 8'd5,   8'd6);
      queue_request(FUNC_SET, 3'd3, 8'd50,  8'd99);
      queue_request(FUNC_SET, 3'd6, 8'd77,  8'd33);    // device out of range, set
      queue_request(FUNC_GET, 3'd7, 8'd0,   8'd0);     // device out of range, get
      queue_request(FUNC_SET, 3'd7, 8'd255, 8'd0);
      queue_request(FUNC_GET, 3'd3, 8'd0,   8'd0);
      queue_request(FUNC_GET, 3'd1, 8'd0,   8'd0);
      queue_request(FUNC_SET, 3'd5, 8'hAA,  8'h55);
      queue_request(FUNC_SET, 3'd4, 8'h7F,  8'h80);
      queue_request(FUNC_SET, 3'd0, 8'd16,  8'd17);
      queue_request(FUNC_SET, 3'd1, 8'd52,  8'd53);
      queue_request(FUNC_GET, 3'd4, 8'hFF,  8'hFF);
      queue_request(FUNC_GET, 3'd5, 8'd0,   8'd0);
      queue_request(FUNC_GET, 3'd6, 8'd0,   8'd0);
      wait_all_done();

      // Flip off, random traffic with idling on both sides.
      write_flip(1'b0);
      queue_random_requests(50);
      wait_all_done();

      // Flip on; first batch, then the sender sits out until all results are in.
      write_flip(1'b1);
      queue_random_requests(30);
      wait_all_done();
      // Second batch with a long response hold while requests keep coming.
      queue_random_requests(30);
      rsp_hold_request = 1'b1;
      wait_all_done();

      // Flip off again, back-to-back with no idling.
      write_flip(1'b0);
      sender_idle_on   = 1'b0;
      receiver_idle_on = 1'b0;
      queue_random_requests(30);
      wait_all_done();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_mixer_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_mixer_results.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: mixer_volume_programmer.f
rtl/mvp_pkg.sv
rtl/mvp_channels.sv
rtl/mixer_volume_programmer.sv
verif/tb.sv
